[rtl/core/rpd_pkg.sv]
package rpd_pkg;

   // field widths of the channels
   localparam int SAMPLE_W    = 16;
   localparam int THRESH_W    = 5;
   localparam int MINVAL_W    = 15;
   localparam int POS_W       = 5;
   localparam int PEAK_W      = 15;
   localparam int OCC_W       = 5;

   // register port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_REPEAT_THRESHOLD = 2'd0;
   localparam csr_index_type REG_MIN_VALUE        = 2'd1;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd3;
   localparam logic [MINVAL_W-1:0] MINVAL_RESET = 15'd1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

[rtl/core/repeated_peak_detector.sv]
// Repeated peak detector.
// Input channel (req_valid / req_stall / req_sample): one signed sample per
// transfer. Samples fill a frame store of FRAME_DEPTH entries. A frame closes
// on the ZERO_RUN_END-th zero in a row (that zero is not stored) or when the
// store becomes full.
// Result channel (rsp_valid / rsp_stall / rsp_*): one result per closed frame,
// giving the largest value at or above min_value that occurs at least
// repeat_threshold times, its first 1-based position and its count; all
// fields zero when nothing qualifies.
// Register port (csr_valid / csr_ready / csr_index / csr_wdata): always ready;
// index 0 is repeat_threshold, index 1 is min_value, others are ignored.
// Flow: a sample that does not close a frame is taken without a stall. At
// close the frame of n samples is scanned through the single read port of
// the store: each candidate is read in turn, and each candidate that passes
// the filter has its count taken over all n stored samples before it is
// compared with repeat_threshold. The input stalls during the scan. The result waits in an
// output register while rsp_stall is high; the next frame is collected
// meanwhile, and a new result is loaded only once the previous one has been
// transferred.
// Reset (synchronous, active high) empties the frame, clears the zero run,
// drops any pending result and restores the register reset values.
module repeated_peak_detector #(
   parameter int FRAME_DEPTH  = 16,
   parameter int ZERO_RUN_END = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [rpd_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_detected,
   output logic        [rpd_pkg::POS_W-1:0]       rsp_first_position,
   output logic        [rpd_pkg::PEAK_W-1:0]      rsp_peak_value,
   output logic        [rpd_pkg::OCC_W-1:0]       rsp_occurrences,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [rpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [rpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW   = $clog2(FRAME_DEPTH);
   localparam int CW   = $clog2(FRAME_DEPTH + 1);
   localparam int ZW   = $clog2(ZERO_RUN_END + 1);
   localparam int CMPW = (CW > rpd_pkg::THRESH_W) ? CW : rpd_pkg::THRESH_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CAND   = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_TAIL   = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   // frame store
   rpd_pkg::sample_type frame_mem [FRAME_DEPTH];
   rpd_pkg::sample_type rd_data_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;

   // control state
   logic [2:0]                     state_ff,   state_in;
   logic [CW-1:0]                  fill_ff,    fill_in;
   logic [ZW-1:0]                  zrun_ff,    zrun_in;
   logic                           found_ff,   found_in;
   logic                           cmp_vld_ff, cmp_vld_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [rpd_pkg::THRESH_W-1:0]   thr_ff,     thr_in;
   logic [rpd_pkg::MINVAL_W-1:0]   minv_ff,    minv_in;

   // scan and result payload
   logic [CW-1:0]                  n_ff,       n_in;
   logic [CW-1:0]                  i_ff,       i_in;
   logic [CW-1:0]                  j_ff,       j_in;
   logic [CW-1:0]                  cnt_ff,     cnt_in;
   rpd_pkg::sample_type            cand_ff,    cand_in;
   rpd_pkg::sample_type            best_ff,    best_in;
   logic [CW-1:0]                  bpos_ff,    bpos_in;
   logic [CW-1:0]                  bcnt_ff,    bcnt_in;
   logic                           det_ff,     det_in;
   logic [rpd_pkg::POS_W-1:0]      opos_ff,    opos_in;
   logic [rpd_pkg::PEAK_W-1:0]     opeak_ff,   opeak_in;
   logic [rpd_pkg::OCC_W-1:0]      oocc_ff,    oocc_in;

   logic [ZW-1:0]   zrun_next;
   logic            zero_close;
   logic            full_close;
   logic [CW-1:0]   fill_next;
   logic            cand_skip;
   logic            cnt_match;
   logic [CMPW-1:0] cnt_ext;
   logic [CMPW-1:0] thr_ext;
   logic [CMPW-1:0] bpos_ext;
   logic [CMPW-1:0] bcnt_ext;
   logic            last_cand;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_detected       = det_ff;
   assign rsp_first_position = opos_ff;
   assign rsp_peak_value     = opeak_ff;
   assign rsp_occurrences    = oocc_ff;

   // frame close decisions for the incoming sample
   assign zrun_next  = zrun_ff + 1'b1;
   assign zero_close = (req_sample == '0) && (zrun_next >= ZW'(ZERO_RUN_END));
   assign fill_next  = fill_ff + 1'b1;
   assign full_close = (fill_next == CW'(FRAME_DEPTH));

   // candidate filter and count compare
   assign cand_skip = ($signed(rd_data_ff) < $signed({1'b0, minv_ff}))
                      || (found_ff && ($signed(rd_data_ff) <= $signed(best_ff)));
   assign cnt_match = cmp_vld_ff && (rd_data_ff == cand_ff);
   assign cnt_ext   = CMPW'(cnt_ff);
   assign thr_ext   = CMPW'(thr_ff);
   assign bpos_ext  = CMPW'(bpos_ff);
   assign bcnt_ext  = CMPW'(bcnt_ff);
   assign last_cand = (i_ff == n_ff - 1'b1);

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      zrun_in    = zrun_ff;
      found_in   = found_ff;
      cmp_vld_in = 1'b0;
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      thr_in     = thr_ff;
      minv_in    = minv_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      cnt_in     = cnt_ff;
      cand_in    = cand_ff;
      best_in    = best_ff;
      bpos_in    = bpos_ff;
      bcnt_in    = bcnt_ff;
      det_in     = det_ff;
      opos_in    = opos_ff;
      opeak_in   = opeak_ff;
      oocc_in    = oocc_ff;
      mem_we     = 1'b0;
      mem_waddr  = fill_ff[AW-1:0];
      mem_raddr  = i_ff[AW-1:0];

      // register writes
      if (csr_valid) begin
         case (csr_index)
            rpd_pkg::REG_REPEAT_THRESHOLD: thr_in  = csr_wdata[rpd_pkg::THRESH_W-1:0];
            rpd_pkg::REG_MIN_VALUE:        minv_in = csr_wdata[rpd_pkg::MINVAL_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               zrun_in = (req_sample == '0) ? zrun_next : '0;
               if (!zero_close) begin
                  mem_we  = 1'b1;
                  fill_in = fill_next;
               end
               if (zero_close || full_close) begin
                  n_in     = zero_close ? fill_ff : fill_next;
                  fill_in  = '0;
                  zrun_in  = '0;
                  i_in     = '0;
                  found_in = 1'b0;
                  if (zero_close && (fill_ff == '0)) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_CAND;
                  end
               end
            end
         end
         S_CAND: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cand_in = rd_data_ff;
            if (cand_skip) begin
               if (last_cand) begin
                  state_in = S_DONE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_CAND;
               end
            end else begin
               j_in     = '0;
               cnt_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one read a cycle, count the data of the previous one
            mem_raddr  = j_ff[AW-1:0];
            cmp_vld_in = 1'b1;
            j_in       = j_ff + 1'b1;
            cnt_in     = cnt_ff + CW'(cnt_match);
            if (j_ff == n_ff - 1'b1) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            cnt_in   = cnt_ff + CW'(cnt_match);
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (cnt_ext >= thr_ext) begin
               found_in = 1'b1;
               best_in  = cand_ff;
               bpos_in  = i_ff + 1'b1;
               bcnt_in  = cnt_ff;
            end
            if (last_cand) begin
               state_in = S_DONE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_CAND;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_vld_ff || !rsp_stall) begin
               rsp_vld_in = 1'b1;
               det_in     = found_ff;
               opos_in    = found_ff ? bpos_ext[rpd_pkg::POS_W-1:0] : '0;
               opeak_in   = found_ff ? best_ff[rpd_pkg::PEAK_W-1:0] : '0;
               oocc_in    = found_ff ? bcnt_ext[rpd_pkg::OCC_W-1:0] : '0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // frame store: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= req_sample;
      end
      rd_data_ff <= frame_mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         zrun_ff    <= '0;
         found_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         thr_ff     <= rpd_pkg::THRESH_RESET;
         minv_ff    <= rpd_pkg::MINVAL_RESET;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         zrun_ff    <= zrun_in;
         found_ff   <= found_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         thr_ff     <= thr_in;
         minv_ff    <= minv_in;
      end
   end

   // scan and result payload
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      cnt_ff   <= cnt_in;
      cand_ff  <= cand_in;
      best_ff  <= best_in;
      bpos_ff  <= bpos_in;
      bcnt_ff  <= bcnt_in;
      det_ff   <= det_in;
      opos_ff  <= opos_in;
      opeak_ff <= opeak_in;
      oocc_ff  <= oocc_in;
   end

`ifndef ASSERT_OFF
   // a result is loaded only from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside frame close");

   // an idle block never holds a full frame
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (fill_ff < CW'(FRAME_DEPTH)))
      else $error("frame store overfilled");

   // a result without detection carries zero fields
   a_no_det_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !det_ff) |-> ((opos_ff == '0) && (opeak_ff == '0) && (oocc_ff == '0)))
      else $error("non-zero fields on a result without detection");

   // the scan counter never passes the frame length
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (j_ff < n_ff))
      else $error("scan index beyond frame");
`endif

endmodule
